FILE: sv/srp_pkg.sv
package srp_pkg;

  // Longest search pattern and longest replacement, in bytes.
  localparam int MAX_PATTERN = 8;
  localparam int REPL_MAX = 8;

  // Width of the pattern and replacement registers.
  localparam int PAT_W = 8 * MAX_PATTERN;
  localparam int REPL_W = 8 * REPL_MAX;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] cnt_t;
  typedef logic [2:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_PATTERN_BYTES     = 3'd0;
  localparam cfg_idx_t REG_PATTERN_LENGTH    = 3'd1;
  localparam cfg_idx_t REG_REPLACEMENT_BYTES = 3'd2;
  localparam cfg_idx_t REG_REPLACEMENT_LEN   = 3'd3;

endpackage

FILE: sv/srp_win_cell.sv
// One position of the held window. The cell keeps one held byte, shows either
// that byte or the incoming byte as its buffer byte, and compares the buffer
// byte against every pattern byte.
module srp_win_cell (
  input  logic                        clk,
  input  logic                        load,
  input  srp_pkg::byte_t              d,
  input  logic                        take_new,
  input  srp_pkg::byte_t              text_byte,
  input  logic [srp_pkg::PAT_W-1:0]   pattern,
  output srp_pkg::byte_t              cur,
  output logic [srp_pkg::MAX_PATTERN-1:0] eq
);

  srp_pkg::byte_t held;

  // Held byte, reloaded from the shifted buffer when a word is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= d;
    end
  end

  // The incoming byte lands just behind the last held byte.
  assign cur = take_new ? text_byte : held;

  // Compare against each pattern byte.
  always_comb begin
    for (int j = 0; j < srp_pkg::MAX_PATTERN; j++) begin
      eq[j] = (cur == pattern[8*j +: 8]);
    end
  end

endmodule

FILE: sv/srp_out_cell.sv
// One stage of the result queue. It is loaded in parallel when a word is
// taken and otherwise hands its byte to the stage in front of it on each pop.
module srp_out_cell (
  input  logic           clk,
  input  logic           load,
  input  srp_pkg::byte_t load_byte,
  input  logic           shift,
  input  srp_pkg::byte_t next_byte,
  output srp_pkg::byte_t q
);

  // Parallel load wins over a shift in the same cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_byte;
    end else if (shift) begin
      q <= next_byte;
    end
  end

endmodule

FILE: sv/stream_pattern_replacer_top.sv
// Streaming find and replace. Text words enter one byte at a time; every
// leftmost, non-overlapping occurrence of the configured pattern (1 to 8
// bytes) is replaced by the configured replacement (0 to 8 bytes). Bytes that
// may still start a match stay in the held window and come out later; on a
// word marked end_of_text everything held is flushed, and if that word yields
// no byte a single word with byte_present low carries end_of_output. An input
// word is taken and its k result words leave through a single output register
// at one per cycle while out_stall is low; the input stalls while more than
// the last result of the previous word is still queued, or while that last
// result is stalled. Writing the pattern or its length drops the held bytes.
// The block needs no clearing pass after reset.
module stream_pattern_replacer_top (
  input  logic                         clk,
  input  logic                         rst,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  srp_pkg::byte_t               text_byte,
  input  logic                         end_of_text,
  // Output channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output srp_pkg::byte_t               out_byte,
  output logic                         byte_present,
  output logic                         end_of_output,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  srp_pkg::cfg_idx_t            cfg_index,
  input  logic [srp_pkg::PAT_W-1:0]    cfg_data
);

  localparam int N = srp_pkg::MAX_PATTERN;

  // Configuration registers.
  logic [srp_pkg::PAT_W-1:0]  pattern_bytes;
  srp_pkg::cnt_t              pattern_length;
  logic [srp_pkg::REPL_W-1:0] replacement_bytes;
  srp_pkg::cnt_t              replacement_length;

  // Control state.
  srp_pkg::cnt_t held_count;
  srp_pkg::cnt_t pend_count;
  logic          q_last;

  // Marker flag for the queued word set.
  logic          marker_held;

  // Window and queue signals.
  srp_pkg::byte_t       cur      [N];
  logic [N-1:0]         eq       [N];
  logic [N-1:0]         take_new;
  srp_pkg::byte_t       held_d   [N];
  srp_pkg::byte_t       q        [srp_pkg::REPL_MAX];
  srp_pkg::byte_t       q_load   [srp_pkg::REPL_MAX];

  logic          in_acc;
  logic          out_acc;
  logic          last;
  logic          full_match;
  logic          marker;
  logic [N-1:0]  ok;
  srp_pkg::cnt_t pat_len;
  srp_pkg::cnt_t repl_len;
  srp_pkg::cnt_t n0;
  srp_pkg::cnt_t n;
  srp_pkg::cnt_t s_min;
  srp_pkg::cnt_t emit_cnt;
  srp_pkg::cnt_t q_count_load;
  srp_pkg::cnt_t held_count_next;

  // Handshakes.
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;
  assign in_stall  = (pend_count > 4'd1) || ((pend_count == 4'd1) && out_stall);
  assign last      = end_of_text;

  // Effective pattern and replacement lengths.
  always_comb begin
    if (pattern_length == 4'd0) begin
      pat_len = 4'd1;
    end else if (pattern_length > 4'(N)) begin
      pat_len = 4'(N);
    end else begin
      pat_len = pattern_length;
    end
    if (replacement_length > 4'(srp_pkg::REPL_MAX)) begin
      repl_len = 4'(srp_pkg::REPL_MAX);
    end else begin
      repl_len = replacement_length;
    end
  end

  // Buffer length: held bytes plus the incoming one.
  assign n0 = (held_count >= pat_len) ? 4'd0 : held_count;
  assign n  = n0 + 4'd1;

  // Row of window cells.
  for (genvar i = 0; i < N; i++) begin : g_win
    assign take_new[i] = (4'(i) == n0);
    srp_win_cell u_cell (
      .clk       (clk),
      .load      (in_acc),
      .d         (held_d[i]),
      .take_new  (take_new[i]),
      .text_byte (text_byte),
      .pattern   (pattern_bytes),
      .cur       (cur[i]),
      .eq        (eq[i])
    );
  end

  // For each shift, whether the buffer tail from there is a pattern prefix.
  always_comb begin
    for (int s = 0; s < N; s++) begin
      ok[s] = 1'b1;
      for (int i = 0; i < N; i++) begin
        if ((i >= s) && (4'(i) < n) && !eq[i][3'(i - s)]) begin
          ok[s] = 1'b0;
        end
      end
    end
  end

  // Smallest shift that leaves a prefix; the whole buffer if none does.
  always_comb begin
    logic found;
    found = 1'b0;
    s_min = n;
    for (int s = 0; s < N; s++) begin
      if (!found && (4'(s) < n) && ok[s]) begin
        s_min = 4'(s);
        found = 1'b1;
      end
    end
  end

  assign full_match = (n == pat_len) && ok[0];

  // Number of bytes this word emits, and the empty end marker.
  always_comb begin
    if (full_match) begin
      emit_cnt = repl_len;
    end else if (last) begin
      emit_cnt = n;
    end else begin
      emit_cnt = s_min;
    end
    marker          = last && (emit_cnt == 4'd0);
    q_count_load    = marker ? 4'd1 : emit_cnt;
    held_count_next = (full_match || last) ? 4'd0 : (n - s_min);
  end

  // New window contents: the buffer moved forward by the shift.
  always_comb begin
    logic [4:0] sh;
    for (int i = 0; i < N; i++) begin
      sh = 5'(i) + {1'b0, s_min};
      held_d[i] = (sh < 5'(N)) ? cur[sh[2:0]] : 8'h00;
    end
  end

  // Result queue: replacement or buffer bytes, zero for the end marker.
  for (genvar j = 0; j < srp_pkg::REPL_MAX; j++) begin : g_out
    assign q_load[j] = marker     ? 8'h00 :
                       full_match ? replacement_bytes[8*j +: 8] : cur[j];
    if (j == srp_pkg::REPL_MAX - 1) begin : g_tail
      srp_out_cell u_cell (
        .clk       (clk),
        .load      (in_acc),
        .load_byte (q_load[j]),
        .shift     (out_acc),
        .next_byte (8'h00),
        .q         (q[j])
      );
    end else begin : g_mid
      srp_out_cell u_cell (
        .clk       (clk),
        .load      (in_acc),
        .load_byte (q_load[j]),
        .shift     (out_acc),
        .next_byte (q[j+1]),
        .q         (q[j])
      );
    end
  end

  // Output word comes from the head of the queue.
  assign out_valid     = (pend_count != 4'd0);
  assign out_byte      = q[0];
  assign byte_present  = (q[0] != 8'h00) || !(q_last && (pend_count == 4'd1)) ||
                         !marker_held;
  assign end_of_output = q_last && (pend_count == 4'd1);

  // Configuration, window count and queue count.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= 4'd0;
      held_count         <= 4'd0;
      pend_count         <= 4'd0;
      q_last             <= 1'b0;
      marker_held        <= 1'b0;
    end else begin
      if (in_acc) begin
        held_count  <= held_count_next;
        pend_count  <= q_count_load;
        q_last      <= last;
        marker_held <= marker;
      end else if (out_acc) begin
        pend_count <= pend_count - 4'd1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srp_pkg::REG_PATTERN_BYTES: begin
            pattern_bytes <= cfg_data;
            held_count    <= 4'd0;
          end
          srp_pkg::REG_PATTERN_LENGTH: begin
            pattern_length <= cfg_data[3:0];
            held_count     <= 4'd0;
          end
          srp_pkg::REG_REPLACEMENT_BYTES: begin
            replacement_bytes <= cfg_data;
          end
          srp_pkg::REG_REPLACEMENT_LEN: begin
            replacement_length <= cfg_data[3:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: sv/srp_checker.sv
// Port-level checks for the find and replace block.
module srp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input srp_pkg::byte_t            text_byte,
  input logic                      end_of_text,
  input logic                      out_valid,
  input logic                      out_stall,
  input srp_pkg::byte_t            out_byte,
  input logic                      byte_present,
  input logic                      end_of_output,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input srp_pkg::cfg_idx_t         cfg_index,
  input logic [srp_pkg::PAT_W-1:0] cfg_data
);

  // Nothing is queued right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // A new word is only taken when the queue holds no stalled result.
  a_in_vs_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && out_valid) |-> !out_stall)
    else $error("input taken while a result is stalled");

  // The final word of a text always yields at least one result.
  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && end_of_text) |=> out_valid)
    else $error("no result after final input word");

  // An empty result is only ever the end marker.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_present) |-> (end_of_output && out_byte == 8'h00))
    else $error("empty result without end mark");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
    else $error("stalled result changed");

endmodule

bind stream_pattern_replacer_top srp_checker u_srp_checker (.*);
